FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Holds the default sizes, field widths, action and status codes and the
// control bundle that the top level hands to every storage cell.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Default sizes of the queue.
    localparam int DEF_CAPACITY = 16;
    localparam int DEF_KEY_BITS = 16;

    // Fixed widths of the result fields.
    localparam int OUT_KEY_W = 16;
    localparam int COUNT_W   = 5;

    // Action codes carried on the input tuser.
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Status codes of a result beat.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Per-cycle command shared by every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

FILE: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one storage cell of the sorted priority queue
// Holds one key. The chain is kept in descending order with the largest key
// in cell 0. On a push the cell keeps its key, takes the new key or takes its
// lower neighbor's key; on a pop it takes its upper neighbor's key.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int KEY_BITS = spq_pkg::DEF_KEY_BITS
) (
    input  logic                   i_clk,
    input  spq_pkg::t_cell_ctl     i_ctl,
    input  logic [KEY_BITS-1:0]    i_new_key,
    input  logic                   i_occupied,
    input  logic                   i_lower_ge,
    input  logic [KEY_BITS-1:0]    i_prev_key,
    input  logic [KEY_BITS-1:0]    i_next_key,
    output logic [KEY_BITS-1:0]    o_key,
    output logic                   o_ge
);

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;

    // A stored key that is not smaller than the new one stays ahead of it, so
    // equal keys leave oldest first.
    assign o_ge = i_occupied && (r_key >= i_new_key);

    // Next key of this cell.
    always_comb begin
        n_key = r_key;
        if (i_ctl.pop) begin
            n_key = i_next_key;
        end else if (i_ctl.push && !o_ge) begin
            if (i_lower_ge) begin
                n_key = i_new_key;
            end else begin
                n_key = i_prev_key;
            end
        end
    end

    // Key register; its contents are meaningless until written.
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;

endmodule

FILE: rtl/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top: bounded priority queue in a chain of key cells
// Each result beat is registered from its accepted input beat and shown in the next cycle.
// Throughput: one push or pop per cycle; every cell compares and shifts at once.
// A result waiting in the output register stalls input only if not taken.
// Reset (synchronous, active low) empties the queue and drops any pending
// result; the key cells are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = spq_pkg::DEF_KEY_BITS,
    localparam int IN_DATA_W = ((KEY_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [KEY_BITS-1:0] key, zero padded
    input  logic                  s_axis_tuser,   // [0] action
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // [15:0] out_key, [20:16] count,
                                                  // [21] is_empty, [23:22] zero
    output logic [2:0]            m_axis_tuser    // [0] out_valid, [2:1] status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Occupancy count.
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;

    // Output register.
    logic                    r_out_vld;
    logic [23:0]             r_out_data;
    logic [2:0]              r_out_user;

    logic                    accept;
    logic                    is_pop;
    logic                    is_full;
    logic                    is_none;
    spq_pkg::t_cell_ctl      ctl;
    spq_pkg::t_status        status;
    logic [KEY_BITS-1:0]     new_key;
    logic [KEY_BITS-1:0]     pop_key;
    logic                    pop_vld;
    logic [spq_pkg::OUT_KEY_W-1:0] out_key;
    logic [spq_pkg::COUNT_W-1:0]   out_count;

    logic [KEY_BITS-1:0]     w_key [CAPACITY];
    logic                    w_ge  [CAPACITY];

    // Handshake: a new beat enters whenever the output register frees up.
    assign s_axis_tready = !r_out_vld || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_pop        = (s_axis_tuser == spq_pkg::ACT_POP);
    assign is_full       = (r_count == CNT_W'(CAPACITY));
    assign is_none       = (r_count == '0);
    assign new_key       = s_axis_tdata[KEY_BITS-1:0];

    // Command to the cells, count update and status.
    always_comb begin
        ctl.push = 1'b0;
        ctl.pop  = 1'b0;
        n_count  = r_count;
        status   = spq_pkg::ST_OK;
        if (accept) begin
            if (!is_pop) begin
                if (is_full) begin
                    status = spq_pkg::ST_FULL;
                end else begin
                    ctl.push = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                end
            end else begin
                if (is_none) begin
                    status = spq_pkg::ST_EMPTY;
                end else begin
                    ctl.pop = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end
            end
        end
    end

    // The largest key always sits in cell 0.
    assign pop_vld = ctl.pop;
    assign pop_key = pop_vld ? w_key[0] : '0;

    // Fit the popped key and the count to their result fields.
    generate
        if (KEY_BITS >= spq_pkg::OUT_KEY_W) begin : g_key_cut
            assign out_key = pop_key[spq_pkg::OUT_KEY_W-1:0];
        end else begin : g_key_ext
            assign out_key = {{(spq_pkg::OUT_KEY_W - KEY_BITS){1'b0}}, pop_key};
        end
        if (CNT_W >= spq_pkg::COUNT_W) begin : g_cnt_cut
            assign out_count = n_count[spq_pkg::COUNT_W-1:0];
        end else begin : g_cnt_ext
            assign out_count = {{(spq_pkg::COUNT_W - CNT_W){1'b0}}, n_count};
        end
    endgenerate

    // Chain of cells, each seeing its two neighbors.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                lower_ge;
            logic [KEY_BITS-1:0] prev_key;
            logic [KEY_BITS-1:0] next_key;

            if (gi == 0) begin : g_first
                assign lower_ge = 1'b1;
                assign prev_key = new_key;
            end else begin : g_mid
                assign lower_ge = w_ge[gi-1];
                assign prev_key = w_key[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign next_key = w_key[gi];
            end else begin : g_inner
                assign next_key = w_key[gi+1];
            end

            spq_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_new_key  (new_key),
                .i_occupied (CNT_W'(gi) < r_count),
                .i_lower_ge (lower_ge),
                .i_prev_key (prev_key),
                .i_next_key (next_key),
                .o_key      (w_key[gi]),
                .o_ge       (w_ge[gi])
            );
        end
    endgenerate

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Result payload, loaded with every accepted beat.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {2'b00, (n_count == '0), out_count, out_key};
            r_out_user <= {status, pop_vld};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
